// ===== rtl/lsms_pkg.sv =====
package lsms_pkg;

    localparam logic [1:0] KIND_TRANSFER  = 2'd0;
    localparam logic [1:0] KIND_WRITEBACK = 2'd1;
    localparam logic [1:0] KIND_UNPRED    = 2'd2;
    localparam logic [1:0] KIND_RESERVED  = 2'd3;

    localparam logic [1:0] SRC_REG  = 2'd0;
    localparam logic [1:0] SRC_BASE = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;

    localparam logic [1:0] OP_IA = 2'd1;
    localparam logic [1:0] OP_DB = 2'd2;

    localparam logic [3:0]  SP_IDX     = 4'd13;
    localparam logic [3:0]  PC_IDX     = 4'd15;
    localparam logic [31:0] WORD_BYTES = 32'd4;

    // Decoded instruction, handed from the front end to the sequencer.
    typedef struct packed {
        logic [1:0]  kind;      // KIND_TRANSFER for a sequence, else a status kind
        logic        is_load;
        logic        wback;
        logic [3:0]  rn;
        logic [15:0] regs;
        logic [3:0]  lowest;
        logic [31:0] addr;
        logic [31:0] new_base;
    } t_cmd;

endpackage

// ===== rtl/lsms_front.sv =====
module lsms_front (
    input  logic              i_valid,
    input  logic              i_full,
    input  logic [31:0]       i_instruction,
    input  logic [31:0]       i_base_value,
    input  logic              i_in_it_block,
    input  logic              i_last_in_it_block,
    output logic              o_stall,
    output logic              o_push,
    output lsms_pkg::t_cmd    o_cmd
);
    import lsms_pkg::*;

    logic [1:0]  op;
    logic        is_load, wbit, pbit, mbit, stackop, bad;
    logic [3:0]  rn;
    logic [15:0] regs;
    logic [4:0]  cnt;
    logic [3:0]  lowest;
    logic [31:0] span, base_dn, base_up, new_base;

    always_comb begin
        op      = i_instruction[24:23];
        is_load = i_instruction[20];
        wbit    = i_instruction[21];
        rn      = i_instruction[19:16];
        pbit    = i_instruction[15];
        mbit    = i_instruction[14];
        stackop = (rn == SP_IDX) && ((is_load && op == OP_IA) || (!is_load && op == OP_DB));

        regs = {is_load & pbit, mbit, 1'b0, i_instruction[12:0]};

        cnt = '0;
        for (int i = 0; i < 16; i++) begin
            cnt = cnt + {4'd0, regs[i]};
        end

        lowest = '0;
        for (int i = 15; i >= 0; i--) begin
            if (regs[i]) begin
                lowest = 4'(i);
            end
        end

        bad = (cnt < 5'd2)
            || (!stackop && rn == PC_IDX)
            || (is_load && pbit && mbit)
            || (is_load && pbit && i_in_it_block && !i_last_in_it_block);

        span    = {25'd0, cnt, 2'b00};
        base_dn = i_base_value - span;
        base_up = i_base_value + span;
        new_base = (op == OP_DB) ? base_dn : base_up;
        if (is_load && regs[rn]) begin
            new_base = '0;
        end

        o_cmd          = '0;
        o_cmd.is_load  = is_load;
        o_cmd.wback    = stackop | wbit;
        o_cmd.rn       = rn;
        o_cmd.regs     = regs;
        o_cmd.lowest   = lowest;
        o_cmd.addr     = (op == OP_DB) ? base_dn : i_base_value;
        o_cmd.new_base = new_base;
        if (op != OP_IA && op != OP_DB) begin
            o_cmd      = '0;
            o_cmd.kind = KIND_RESERVED;
        end else if (bad) begin
            o_cmd      = '0;
            o_cmd.kind = KIND_UNPRED;
        end else begin
            o_cmd.kind = KIND_TRANSFER;
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// ===== rtl/lsms_queue.sv =====
module lsms_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lsms_pkg::t_cmd    i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output lsms_pkg::t_cmd    o_data
);
    import lsms_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

// ===== rtl/lsms_back.sv =====
module lsms_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  lsms_pkg::t_cmd    i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_kind,
    output logic              o_is_store,
    output logic [31:0]       o_address,
    output logic [3:0]        o_reg_index,
    output logic [1:0]        o_store_source,
    output logic              o_load_discarded,
    output logic [31:0]       o_writeback_value,
    output logic              o_last
);
    import lsms_pkg::*;

    logic        r_active, r_wb_pend;
    t_cmd        r_cur;
    logic        r_out_valid, r_is_store, r_load_discarded, r_last;
    logic [1:0]  r_kind, r_store_source;
    logic [31:0] r_address, r_writeback_value;
    logic [3:0]  r_reg_index;

    t_cmd        v, n_cur;
    logic        wb_pend, have, adv, n_wb_pend, n_is_store, n_load_discarded, n_last;
    logic [1:0]  n_kind, n_store_source;
    logic [31:0] n_address, n_writeback_value;
    logic [3:0]  n_reg_index, pick;
    logic [15:0] rem_next;

    always_comb begin
        v       = r_active ? r_cur : i_head;
        wb_pend = r_active ? r_wb_pend : i_head.wback;
        have    = r_active || i_head_valid;
        adv     = have && (!r_out_valid || !i_out_stall);

        pick = '0;
        for (int i = 15; i >= 0; i--) begin
            if (v.regs[i]) begin
                pick = 4'(i);
            end
        end
        rem_next       = v.regs;
        rem_next[pick] = 1'b0;

        n_cur             = v;
        n_wb_pend         = 1'b0;
        n_kind            = v.kind;
        n_is_store        = 1'b0;
        n_address         = '0;
        n_reg_index       = '0;
        n_store_source    = SRC_REG;
        n_load_discarded  = 1'b0;
        n_writeback_value = '0;
        n_last            = 1'b1;

        if (v.kind != KIND_TRANSFER) begin
            // status result: all payload zero, single beat
        end else if (wb_pend) begin
            n_kind            = KIND_WRITEBACK;
            n_is_store        = !v.is_load;
            n_reg_index       = v.rn;
            n_writeback_value = v.new_base;
            n_last            = (v.regs == '0);
        end else begin
            n_kind      = KIND_TRANSFER;
            n_is_store  = !v.is_load;
            n_address   = v.addr;
            n_reg_index = pick;
            if (v.wback && pick == v.rn) begin
                if (v.is_load) begin
                    n_load_discarded = 1'b1;
                end else begin
                    n_store_source = (pick == v.lowest) ? SRC_BASE : SRC_ZERO;
                end
            end
            n_last     = (rem_next == '0);
            n_cur.regs = rem_next;
            n_cur.addr = v.addr + WORD_BYTES;
        end
    end

    assign o_pop = adv && !r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid       <= 1'b1;
                r_active          <= !n_last;
                r_cur             <= n_cur;
                r_wb_pend         <= n_wb_pend;
                r_kind            <= n_kind;
                r_is_store        <= n_is_store;
                r_address         <= n_address;
                r_reg_index       <= n_reg_index;
                r_store_source    <= n_store_source;
                r_load_discarded  <= n_load_discarded;
                r_writeback_value <= n_writeback_value;
                r_last            <= n_last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_is_store        = r_is_store;
    assign o_address         = r_address;
    assign o_reg_index       = r_reg_index;
    assign o_store_source    = r_store_source;
    assign o_load_discarded  = r_load_discarded;
    assign o_writeback_value = r_writeback_value;
    assign o_last            = r_last;

endmodule

// ===== rtl/load_store_multiple_sequencer_top.sv =====
// Channel | Direction | Handshake               | Beat payload
// in      | input     | i_in_valid / o_in_stall | instruction, base value, IT-block flags
// out     | output    | o_out_valid/i_out_stall | one writeback, transfer or status result
//
// Throughput: one result beat per cycle while i_out_stall is low; a status result is
//   a single beat, a sequence one transfer beat per listed register, preceded by a
//   writeback beat when writeback is on: a legal list holds at most 14 registers
//   (r13 never, PC only on loads and never together with LR).
// Reset: synchronous, active low; clears the decode queue and the output valid flag.
// Stalls: the front end stalls only when the decode queue is full; the sequencer
//   holds a valid output beat while i_out_stall is high.
module load_store_multiple_sequencer_top #(
    parameter int QUEUE_DEPTH = 2   // decoded instructions buffered, at least 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_instruction,
    input  logic [31:0] i_base_value,
    input  logic        i_in_it_block,
    input  logic        i_last_in_it_block,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic        o_is_store,
    output logic [31:0] o_address,
    output logic [3:0]  o_reg_index,
    output logic [1:0]  o_store_source,
    output logic        o_load_discarded,
    output logic [31:0] o_writeback_value,
    output logic        o_last
);
    import lsms_pkg::*;

    t_cmd push_cmd, head_cmd;
    logic push, pop, full, head_valid;

    // Front end: decode the form, the register list, the unpredictable cases,
    // the start address and the new base in a single combinational pass.
    lsms_front u_front (
        .i_valid            (i_in_valid),
        .i_full             (full),
        .i_instruction      (i_instruction),
        .i_base_value       (i_base_value),
        .i_in_it_block      (i_in_it_block),
        .i_last_in_it_block (i_last_in_it_block),
        .o_stall            (o_in_stall),
        .o_push             (push),
        .o_cmd              (push_cmd)
    );

    // Short decode queue: lets the front take the next instruction while the
    // back end is still walking through a long register list.
    lsms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_data  (head_cmd)
    );

    // Back end: any writeback beat first, then one transfer per set bit, lowest
    // register first; the first beat is taken straight from the queue head.
    lsms_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head_valid      (head_valid),
        .i_head            (head_cmd),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_kind            (o_kind),
        .o_is_store        (o_is_store),
        .o_address         (o_address),
        .o_reg_index       (o_reg_index),
        .o_store_source    (o_store_source),
        .o_load_discarded  (o_load_discarded),
        .o_writeback_value (o_writeback_value),
        .o_last            (o_last)
    );

endmodule

// ===== rtl/lsms_checker.sv =====
module lsms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [31:0] o_address,
    input logic [1:0]  o_store_source,
    input logic        o_load_discarded,
    input logic [31:0] o_writeback_value,
    input logic        o_last
);
    import lsms_pkg::*;

    // A stalled beat stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
            && $stable(o_address) && $stable(o_last))
        else $error("stalled output beat changed");

    // Status results are always single-beat.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_UNPRED || o_kind == KIND_RESERVED) |-> o_last)
        else $error("status result not marked last");

    // A writeback is always followed by at least two transfers.
    a_wb_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_WRITEBACK |-> !o_last && o_address == '0)
        else $error("writeback beat marked last or carries an address");

    // Only transfers carry store source or discard, only writebacks a new base.
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_TRANSFER |-> o_store_source == SRC_REG
            && !o_load_discarded)
        else $error("non-transfer beat carries transfer fields");

    a_wb_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_WRITEBACK |-> o_writeback_value == '0)
        else $error("non-writeback beat carries a base value");

endmodule

bind load_store_multiple_sequencer_top lsms_checker u_lsms_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_kind            (o_kind),
    .o_address         (o_address),
    .o_store_source    (o_store_source),
    .o_load_discarded  (o_load_discarded),
    .o_writeback_value (o_writeback_value),
    .o_last            (o_last)
);

// ===== verif/tb_load_store_multiple_sequencer_top.sv =====
`timescale 1ns / 100ps

module tb_load_store_multiple_sequencer_top;
    import lsms_pkg::*;

    // One result beat, packed in output port order so it can be built from the ports.
    typedef struct packed {
        logic [1:0]  kind;
        logic        is_store;
        logic [31:0] address;
        logic [3:0]  reg_index;
        logic [1:0]  store_source;
        logic        load_discarded;
        logic [31:0] writeback_value;
        logic        last;
    } t_lsm_beat;

    // One directed row. When typed is set, the single status beat of the given kind
    // is what the row must produce. Otherwise the predictor supplies the beats.
    typedef struct packed {
        logic [31:0] ins;
        logic [31:0] base;
        logic        in_it;
        logic        it_last;
        logic        typed;
        logic [1:0]  kind;
    } t_stim_row;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_in_valid         = 1'b0;
    logic [31:0] i_instruction      = '0;
    logic [31:0] i_base_value       = '0;
    logic        i_in_it_block      = 1'b0;
    logic        i_last_in_it_block = 1'b0;
    logic        i_out_stall        = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic        o_is_store;
    logic [31:0] o_address;
    logic [3:0]  o_reg_index;
    logic [1:0]  o_store_source;
    logic        o_load_discarded;
    logic [31:0] o_writeback_value;
    logic        o_last;

    load_store_multiple_sequencer_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_instruction      (i_instruction),
        .i_base_value       (i_base_value),
        .i_in_it_block      (i_in_it_block),
        .i_last_in_it_block (i_last_in_it_block),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_kind             (o_kind),
        .o_is_store         (o_is_store),
        .o_address          (o_address),
        .o_reg_index        (o_reg_index),
        .o_store_source     (o_store_source),
        .o_load_discarded   (o_load_discarded),
        .o_writeback_value  (o_writeback_value),
        .o_last             (o_last)
    );

    always #1 i_clk = ~i_clk;

    t_lsm_beat predicted_beats[$];   // result beats still owed by the block, oldest first
    t_stim_row stim_rows[$];
    int        mismatches = 0;
    bit        idle_on    = 1'b1;    // both sides insert random gaps while set

    // Thumb-2 LDM/STM encoding: 1110100 op 0 W L Rn P M 0 list
    function automatic logic [31:0] enc_ldm(input logic [1:0] op, input logic wb,
                                            input logic ld, input logic [3:0] rn,
                                            input logic p, input logic m,
                                            input logic [12:0] list);
        return {7'b1110100, op, 1'b0, wb, ld, rn, p, m, 1'b0, list};
    endfunction

    function automatic t_lsm_beat mk_beat(input logic [1:0] kind, input logic st,
                                          input logic [31:0] addr, input logic [3:0] rix,
                                          input logic [1:0] src, input logic disc,
                                          input logic [31:0] wb, input logic last);
        return {kind, st, addr, rix, src, disc, wb, last};
    endfunction

    task automatic add_row(input logic [31:0] ins, input logic [31:0] base,
                           input logic in_it, input logic it_last,
                           input logic typed, input logic [1:0] kind);
        stim_rows.push_back({ins, base, in_it, it_last, typed, kind});
    endtask

    // Decode one instruction and queue the beats it must produce: status beat, or
    // optional writeback then one transfer per listed register, ascending.
    task automatic predict_sequence(input logic [31:0] ins, input logic [31:0] base,
                                    input logic in_it, input logic it_last);
        logic [1:0]  op;
        logic [1:0]  src;
        logic        load, wbit, pbit, mbit, stackop, wback, bad;
        logic [3:0]  rn, lowest;
        logic [15:0] regs;
        logic [31:0] span, addr, new_base;
        int          cnt, k;

        op   = ins[24:23];
        load = ins[20];
        wbit = ins[21];
        rn   = ins[19:16];
        pbit = ins[15];
        mbit = ins[14];
        stackop = (rn == SP_IDX) && ((load && op == OP_IA) || (!load && op == OP_DB));

        if (op != OP_IA && op != OP_DB) begin
            predicted_beats.push_back(mk_beat(KIND_RESERVED, 0, '0, '0, SRC_REG, 0, '0, 1));
            return;
        end

        // PC only via P on loads, LR via M, bit 13 never
        regs = {load & pbit, mbit, 1'b0, ins[12:0]};
        cnt = 0;
        lowest = '0;
        for (int j = 15; j >= 0; j--) begin
            if (regs[j]) begin
                cnt++;
                lowest = 4'(j);
            end
        end

        bad = (cnt < 2) || (!stackop && rn == PC_IDX) || (load && pbit && mbit)
              || (load && pbit && in_it && !it_last);
        if (bad) begin
            predicted_beats.push_back(mk_beat(KIND_UNPRED, 0, '0, '0, SRC_REG, 0, '0, 1));
            return;
        end

        span     = WORD_BYTES * 32'(cnt);
        wback    = stackop || wbit;
        addr     = (op == OP_DB) ? base - span : base;
        new_base = (op == OP_DB) ? base - span : base + span;
        if (load && regs[rn])
            new_base = '0;

        if (wback)
            predicted_beats.push_back(mk_beat(KIND_WRITEBACK, !load, '0, rn, SRC_REG, 0,
                                              new_base, 0));

        k = 0;
        for (int j = 0; j < 16; j++) begin
            if (regs[j]) begin
                k++;
                src = SRC_REG;
                if (!load && wback && 4'(j) == rn)
                    src = (4'(j) == lowest) ? SRC_BASE : SRC_ZERO;
                predicted_beats.push_back(mk_beat(KIND_TRANSFER, !load, addr, 4'(j), src,
                                                  load && wback && 4'(j) == rn, '0,
                                                  k == cnt));
                addr += WORD_BYTES;
            end
        end
    endtask

    // Present one instruction beat after a random gap and hold it until accepted.
    // Expectations are queued at the accepting edge, before any result can appear.
    task automatic send_beat(input logic [31:0] ins, input logic [31:0] base,
                             input logic in_it, input logic it_last,
                             input logic typed, input logic [1:0] kind);
        int gap;

        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_instruction      <= ins;
        i_base_value       <= base;
        i_in_it_block      <= in_it;
        i_last_in_it_block <= it_last;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        if (typed)
            predicted_beats.push_back(mk_beat(kind, 0, '0, '0, SRC_REG, 0, '0, 1));
        else
            predict_sequence(ins, base, in_it, it_last);
    endtask

    // Hold the input side idle until every queued beat has come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (predicted_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result side: compare every accepted beat with the oldest expectation.
    always @(posedge i_clk) begin : out_check
        t_lsm_beat got, want;
        if (i_rst_n) begin
            if ($isunknown(o_out_valid)) begin
                $display("%0t: o_out_valid expected 0 or 1, got %b", $time, o_out_valid);
                mismatches++;
            end else if (o_out_valid && !i_out_stall) begin
                got = {o_kind, o_is_store, o_address, o_reg_index, o_store_source,
                       o_load_discarded, o_writeback_value, o_last};
                if (predicted_beats.size() == 0) begin
                    $display("%0t: result beat expected none, got 0x%0h", $time, got);
                    mismatches++;
                end else begin
                    want = predicted_beats.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("is_store", want.is_store, got.is_store);
                    check_field("address", want.address, got.address);
                    check_field("reg_index", want.reg_index, got.reg_index);
                    check_field("store_source", want.store_source, got.store_source);
                    check_field("load_discarded", want.load_discarded, got.load_discarded);
                    check_field("writeback_value", want.writeback_value,
                                got.writeback_value);
                    check_field("last", want.last, got.last);
                end
            end
        end
    end

    // Result side stall: random hold before each beat, none while idling is off.
    initial begin : out_stall_gen
        int hold;
        @(posedge i_clk);
        forever begin
            hold = idle_on ? $urandom_range(0, 6) : 0;
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (o_out_valid !== 1'b1 || i_out_stall) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        logic [31:0] ins, base;
        int          sel;

        // Valid sequences: one per form, wrap at both ends of the address space
        add_row(enc_ldm(OP_IA, 1, 0, 4'd0, 0, 0, 13'h0006), 32'h0000_1000, 0, 0, 0,
                KIND_TRANSFER);                                    // STMIA r0!, {r1,r2}
        add_row(enc_ldm(OP_IA, 0, 1, 4'd1, 1, 0, 13'h1FFF), 32'hFFFF_FFF0, 0, 0, 0,
                KIND_TRANSFER);                                    // LDMIA all + PC, wraps
        add_row(enc_ldm(OP_DB, 1, 1, 4'd2, 0, 1, 13'h1FFF), 32'h0000_0000, 0, 0, 0,
                KIND_TRANSFER);                                    // LDMDB r2!, base listed
        add_row(enc_ldm(OP_IA, 0, 1, SP_IDX, 1, 0, 13'h0030), 32'h2000_0100, 0, 0, 0,
                KIND_TRANSFER);                                    // POP {r4,r5,pc}
        add_row(enc_ldm(OP_DB, 0, 0, SP_IDX, 0, 1, 13'h00F0), 32'h2000_0000, 0, 0, 0,
                KIND_TRANSFER);                                    // PUSH {r4-r7,lr}
        add_row(enc_ldm(OP_DB, 0, 0, 4'd3, 0, 0, 13'h0003), 32'h0000_0004, 0, 0, 0,
                KIND_TRANSFER);                                    // STMDB r3, wraps
        // Reserved op field, all-zero and all-one words
        add_row(32'h0000_0000, 32'h0000_0000, 0, 0, 1, KIND_RESERVED);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, KIND_RESERVED);
        // Unpredictable: one register, no register, Rn = PC, PC with LR, PC mid IT block
        add_row(enc_ldm(OP_IA, 1, 1, 4'd0, 0, 0, 13'h0001), 32'h100, 0, 0, 1, KIND_UNPRED);
        add_row(enc_ldm(OP_DB, 0, 0, 4'd0, 0, 0, 13'h0000), 32'h100, 0, 0, 1, KIND_UNPRED);
        add_row(enc_ldm(OP_IA, 0, 0, PC_IDX, 0, 0, 13'h0003), 32'h100, 0, 0, 1, KIND_UNPRED);
        add_row(enc_ldm(OP_DB, 1, 1, PC_IDX, 0, 0, 13'h00FF), 32'h100, 0, 0, 1, KIND_UNPRED);
        add_row(enc_ldm(OP_IA, 0, 1, 4'd0, 1, 1, 13'h0006), 32'h100, 0, 0, 1, KIND_UNPRED);
        add_row(enc_ldm(OP_IA, 0, 1, 4'd0, 1, 0, 13'h0006), 32'h100, 1, 0, 1, KIND_UNPRED);
        // Same load of PC as the last instruction of the IT block is legal
        add_row(enc_ldm(OP_IA, 0, 1, 4'd0, 1, 0, 13'h0006), 32'h100, 1, 1, 0, KIND_TRANSFER);
        // Base register inside the list under writeback
        add_row(enc_ldm(OP_IA, 1, 1, 4'd4, 0, 0, 13'h0054), 32'h8000_0000, 0, 0, 0,
                KIND_TRANSFER);                                    // load: discarded
        add_row(enc_ldm(OP_IA, 1, 0, 4'd1, 0, 0, 13'h0022), 32'h0000_2000, 0, 0, 0,
                KIND_TRANSFER);                                    // store: base lowest
        add_row(enc_ldm(OP_DB, 1, 0, 4'd5, 0, 0, 13'h0021), 32'h0000_2000, 0, 0, 0,
                KIND_TRANSFER);                                    // store: zero data
        add_row(enc_ldm(OP_IA, 0, 0, 4'd1, 0, 0, 13'h0006), 32'h0000_2000, 0, 0, 0,
                KIND_TRANSFER);                                    // store, no writeback
        // P ignored on stores, M adds LR; ignored bits 13 and 22 set
        add_row(enc_ldm(OP_IA, 0, 0, 4'd6, 1, 1, 13'h0001), 32'h0000_3000, 0, 0, 0,
                KIND_TRANSFER);
        add_row(enc_ldm(OP_IA, 1, 1, 4'd7, 0, 0, 13'h0180) | 32'h0040_2000, 32'h10, 0, 0, 0,
                KIND_TRANSFER);
        // SP as base without being a stack form
        add_row(enc_ldm(OP_DB, 1, 1, SP_IDX, 0, 0, 13'h0011), 32'h0000_4000, 0, 0, 0,
                KIND_TRANSFER);
        add_row(enc_ldm(OP_IA, 1, 0, SP_IDX, 0, 0, 13'h0003), 32'h0000_4000, 0, 0, 0,
                KIND_TRANSFER);
        // Longest store: thirteen registers plus LR at the top of memory
        add_row(enc_ldm(OP_DB, 1, 0, 4'd0, 0, 1, 13'h1FFF), 32'hFFFF_FFFF, 0, 0, 0,
                KIND_TRANSFER);
        add_row(enc_ldm(OP_IA, 0, 1, SP_IDX, 1, 0, 13'h0001), 32'h0000_0FFC, 1, 1, 0,
                KIND_TRANSFER);                                    // POP {r0,pc}, IT last

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[r])
            send_beat(stim_rows[r].ins, stim_rows[r].base, stim_rows[r].in_it,
                      stim_rows[r].it_last, stim_rows[r].typed, stim_rows[r].kind);
        drain_results();

        // Random part: mostly well-formed LDM/STM words with random content, some noise.
        // Segment 1 runs with no idling on either side.
        for (int seg = 0; seg < 7; seg++) begin
            idle_on = (seg == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 36; n++) begin
                sel = $urandom_range(0, 99);
                ins = $urandom();
                if (sel >= 10) begin
                    ins[24:23] = $urandom_range(0, 1) ? OP_DB : OP_IA;
                    sel = $urandom_range(0, 9);
                    ins[19:16] = (sel < 3) ? SP_IDX :
                                 (sel == 3) ? PC_IDX : 4'($urandom_range(0, 14));
                    sel = $urandom_range(0, 9);
                    if (sel == 0)
                        ins[12:0] = 13'(1 << $urandom_range(0, 12));
                    else if (sel == 1)
                        ins[12:0] = 13'h1FFF;
                    else
                        ins[12:0] = ins[12:0] & 13'($urandom());
                    // keep most PC loads legal by dropping LR
                    if (ins[20] && ins[15] && ins[14] && $urandom_range(0, 3) != 0)
                        ins[14] = 1'b0;
                end
                sel = $urandom_range(0, 9);
                base = (sel == 0) ? 32'($urandom_range(0, 64)) :
                       (sel == 1) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 64)) : $urandom();
                send_beat(ins, base, $urandom_range(0, 1), $urandom_range(0, 1), 0,
                          KIND_TRANSFER);
            end
            if (seg == 3)
                drain_results();
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (predicted_beats.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && predicted_beats.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin : watchdog
        #500_000;
        $display("%0t: timeout, %0d result beats outstanding", $time, predicted_beats.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
